// File: rtl/timed_ip_blocklist_table_defines.svh
// Assertion macros shared by the blocklist table.
// All three sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef TIMED_IP_BLOCKLIST_TABLE_DEFINES_SVH
`define TIMED_IP_BLOCKLIST_TABLE_DEFINES_SVH

// A property that must hold at every edge out of reset.
`define TIBT_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("blocklist table check failed");

// An implication checked in the same cycle.
`define TIBT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("blocklist table check failed");

// An implication checked in the next cycle.
`define TIBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("blocklist table check failed");

`endif

// File: rtl/tibt_pkg.sv
package tibt_pkg;

    // Default table depth.
    localparam int TableEntriesDefault = 64;

    // Field widths.
    localparam int AddrW   = 32;
    localparam int TimeW   = 32;
    localparam int CountW  = 16;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 32;

    // Configuration register defaults.
    localparam logic [TimeW-1:0]  SanctionReset  = TimeW'(600);
    localparam logic [CountW-1:0] TriggerReset   = CountW'(10);
    localparam logic [CountW-1:0] ThresholdReset = CountW'(3);

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SANCTION  = 2'd0,
        CFG_TRIGGER   = 2'd1,
        CFG_THRESHOLD = 2'd2
    } t_cfg_idx;

    // Request types.
    typedef enum logic {
        REQ_REGISTER = 1'b0,
        REQ_CHECK    = 1'b1
    } t_req;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Table update operations.
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_INSERT  = 2'd1,
        OP_REFRESH = 2'd2,
        OP_REMOVE  = 2'd3
    } t_op;

    // Update command from the request logic to every entry.
    typedef struct packed {
        t_op               op;
        logic [CountW-1:0] offenses;
        logic [TimeW-1:0]  expiry;
    } t_update;

    // Lookup result from the table for the current key.
    typedef struct packed {
        logic              hit;
        logic              free_found;
        logic [CountW-1:0] offenses;
        logic [TimeW-1:0]  expiry;
    } t_lookup;

endpackage

// File: rtl/tibt_cell.sv
module tibt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tibt_pkg::AddrW-1:0] i_key,
    input  tibt_pkg::t_update         i_cmd,
    input  logic                      i_free_sel,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic [tibt_pkg::CountW-1:0] o_offenses,
    output logic [tibt_pkg::TimeW-1:0]  o_expiry
);
    import tibt_pkg::*;

    logic              r_valid;
    logic [AddrW-1:0]  r_address;
    logic [CountW-1:0] r_offenses;
    logic [TimeW-1:0]  r_expiry;
    logic              n_valid;
    logic [AddrW-1:0]  n_address;
    logic [CountW-1:0] n_offenses;
    logic [TimeW-1:0]  n_expiry;
    logic              w_hit;

    // Compare the stored address against the key.
    assign w_hit = r_valid && (r_address == i_key);

    // Apply the update if this entry is the one it targets.
    always_comb begin
        n_valid    = r_valid;
        n_address  = r_address;
        n_offenses = r_offenses;
        n_expiry   = r_expiry;
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_INSERT: begin
                if (i_free_sel) begin
                    n_valid    = 1'b1;
                    n_address  = i_key;
                    n_offenses = i_cmd.offenses;
                    n_expiry   = i_cmd.expiry;
                end
            end
            OP_REFRESH: begin
                if (w_hit) begin
                    n_offenses = i_cmd.offenses;
                    n_expiry   = i_cmd.expiry;
                end
            end
            OP_REMOVE: begin
                if (w_hit) begin
                    n_valid = 1'b0;
                end
            end
        endcase
    end

    // Only the valid bit is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_address  <= n_address;
        r_offenses <= n_offenses;
        r_expiry   <= n_expiry;
    end

    assign o_valid    = r_valid;
    assign o_hit      = w_hit;
    assign o_offenses = r_offenses;
    assign o_expiry   = r_expiry;

endmodule

// File: rtl/tibt_table.sv
module tibt_table #(
    parameter int TABLE_ENTRIES = tibt_pkg::TableEntriesDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tibt_pkg::AddrW-1:0] i_key,
    input  tibt_pkg::t_update          i_cmd,
    output tibt_pkg::t_lookup          o_lookup,
    output logic [TABLE_ENTRIES-1:0]   o_hit_vec
);
    import tibt_pkg::*;

    logic [TABLE_ENTRIES-1:0] w_valid;
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [TABLE_ENTRIES-1:0] w_free;
    logic [TABLE_ENTRIES-1:0] w_free_sel;
    logic [CountW-1:0]        w_offenses [TABLE_ENTRIES];
    logic [TimeW-1:0]         w_expiry   [TABLE_ENTRIES];
    logic [CountW-1:0]        w_hit_offenses;
    logic [TimeW-1:0]         w_hit_expiry;

    // One associative entry per slot.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        tibt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (i_key),
            .i_cmd      (i_cmd),
            .i_free_sel (w_free_sel[g]),
            .o_valid    (w_valid[g]),
            .o_hit      (w_hit[g]),
            .o_offenses (w_offenses[g]),
            .o_expiry   (w_expiry[g])
        );
    end

    // Isolate the lowest free slot: x & -x on the free vector.
    assign w_free     = ~w_valid;
    assign w_free_sel = w_free & (~w_free + TABLE_ENTRIES'(1));

    // One-hot select of the matching entry's fields.
    always_comb begin
        w_hit_offenses = '0;
        w_hit_expiry   = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_hit_offenses = w_hit_offenses | (w_offenses[i] & {CountW{w_hit[i]}});
            w_hit_expiry   = w_hit_expiry | (w_expiry[i] & {TimeW{w_hit[i]}});
        end
    end

    assign o_lookup.hit        = |w_hit;
    assign o_lookup.free_found = |w_free;
    assign o_lookup.offenses   = w_hit_offenses;
    assign o_lookup.expiry     = w_hit_expiry;
    assign o_hit_vec           = w_hit;

endmodule

// File: rtl/timed_ip_blocklist_table.sv
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_stall    req_type, ip_address, session_count,
//                                                 now_seconds
// out       from block o_out_valid / i_out_stall  is_bad, status
// cfg       to block   i_cfg_we                   i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; each item passes through the input
// register, then lookup and update into the result register.
// Every entry compares its address in parallel, so the lookup is combinational at any depth.
// Reset clears all valid bits at once and loads the register defaults.
// A stalled result holds; the input register then fills and o_in_stall rises.
`include "timed_ip_blocklist_table_defines.svh"

module timed_ip_blocklist_table #(
    parameter int TABLE_ENTRIES = tibt_pkg::TableEntriesDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [tibt_pkg::AddrW-1:0]    i_ip_address,
    input  logic [tibt_pkg::CountW-1:0]   i_session_count,
    input  logic [tibt_pkg::TimeW-1:0]    i_now_seconds,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_is_bad,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic [tibt_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [tibt_pkg::CfgDataW-1:0] i_cfg_data
);
    import tibt_pkg::*;

    logic [TimeW-1:0]  r_sanction_s;
    logic [CountW-1:0] r_trigger;
    logic [CountW-1:0] r_threshold;

    logic              r_in_valid;
    logic              r_req_type;
    logic [AddrW-1:0]  r_ip_address;
    logic [CountW-1:0] r_session_count;
    logic [TimeW-1:0]  r_now_seconds;

    logic              r_out_valid;
    logic              r_is_bad;
    t_status           r_status;

    logic              w_fire;
    logic              w_in_xfer;
    t_lookup           w_lookup;
    t_update           w_cmd;
    logic [TABLE_ENTRIES-1:0] w_hit_vec;
    logic [TimeW:0]    w_sum;
    logic [TimeW-1:0]  w_expiry;
    logic [CountW-1:0] w_offenses_inc;
    logic              n_is_bad;
    t_status           n_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sanction_s <= SanctionReset;
            r_trigger    <= TriggerReset;
            r_threshold  <= ThresholdReset;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SANCTION:  r_sanction_s <= i_cfg_data;
                    CFG_TRIGGER:   r_trigger    <= i_cfg_data[CountW-1:0];
                    CFG_THRESHOLD: r_threshold  <= i_cfg_data[CountW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // The lookup stage fires when the result register is free or draining.
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req_type      <= i_req_type;
            r_ip_address    <= i_ip_address;
            r_session_count <= i_session_count;
            r_now_seconds   <= i_now_seconds;
        end
    end

    // Associative table.
    tibt_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (r_ip_address),
        .i_cmd     (w_cmd),
        .o_lookup  (w_lookup),
        .o_hit_vec (w_hit_vec)
    );

    // New expiry saturates at the top of the time range.
    assign w_sum    = {1'b0, r_now_seconds} + {1'b0, r_sanction_s};
    assign w_expiry = w_sum[TimeW] ? {TimeW{1'b1}} : w_sum[TimeW-1:0];

    // Offense count stops at its maximum.
    assign w_offenses_inc = (&w_lookup.offenses) ? w_lookup.offenses
                                                 : w_lookup.offenses + CountW'(1);

    // Request decision and table update command.
    always_comb begin
        n_is_bad       = 1'b0;
        n_status       = ST_OK;
        w_cmd.op       = OP_NONE;
        w_cmd.offenses = w_offenses_inc;
        w_cmd.expiry   = w_expiry;
        if (r_ip_address == '0) begin
            n_status = ST_INVALID;
        end else if (r_req_type == REQ_REGISTER) begin
            if (w_lookup.hit) begin
                w_cmd.op = OP_REFRESH;
            end else if (w_lookup.free_found) begin
                w_cmd.op       = OP_INSERT;
                w_cmd.offenses = CountW'(1);
            end else begin
                n_status = ST_FULL;
            end
        end else if ((r_session_count >= r_trigger) && w_lookup.hit) begin
            if (w_lookup.expiry < r_now_seconds) begin
                w_cmd.op = OP_REMOVE;
            end else begin
                n_is_bad = (w_lookup.offenses >= r_threshold);
            end
        end
        // The table changes only when the item actually moves on.
        if (!w_fire) begin
            w_cmd.op = OP_NONE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_is_bad <= n_is_bad;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_bad    = r_is_bad;
    assign o_status    = r_status;

    // At most one entry may ever hold a given address.
    `TIBT_ASSERT(a_single_hit, $onehot0(w_hit_vec))
    // An insert happens only for an absent key with room in the table.
    `TIBT_ASSERT_IMP(a_insert_ok, w_cmd.op == OP_INSERT,
                     !w_lookup.hit && w_lookup.free_found)
    // A bad verdict only comes with an ok status.
    `TIBT_ASSERT_IMP(a_bad_status, r_out_valid && r_is_bad, r_status == ST_OK)
    // Every firing item produces a result on the next cycle.
    `TIBT_ASSERT_NEXT(a_fire_result, w_fire, r_out_valid)

endmodule
